// ===== rtl/core/pfc_pkg.sv =====
// Shared types and constants for the pixel format converter core.
// No dependencies; imported by every module of the core.
package pfc_pkg;

  // conversion_mode codes; 4..7 produce an empty result
  localparam logic [2:0] MODE_COPY  = 3'd0;
  localparam logic [2:0] MODE_RGB24 = 3'd1;
  localparam logic [2:0] MODE_YCC   = 3'd2;
  localparam logic [2:0] MODE_YUYV  = 3'd3;

  // YCbCr to RGB, Q16
  localparam logic signed [17:0] Q_CR_R = 18'sd89849;
  localparam logic signed [17:0] Q_CR_G = 18'sd45744;
  localparam logic signed [17:0] Q_CB_G = 18'sd22020;
  localparam logic signed [17:0] Q_CB_B = 18'sd113508;

  // RGB to YCbCr, Q8
  localparam logic [7:0] C_Y_R  = 8'd77;
  localparam logic [7:0] C_Y_G  = 8'd150;
  localparam logic [7:0] C_Y_B  = 8'd29;
  localparam logic [7:0] C_CB_R = 8'd44;
  localparam logic [7:0] C_CB_G = 8'd87;
  localparam logic [7:0] C_CB_B = 8'd131;
  localparam logic [7:0] C_CR_R = 8'd131;
  localparam logic [7:0] C_CR_G = 8'd110;
  localparam logic [7:0] C_CR_B = 8'd21;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // one item as it moves down the pipe
  typedef struct packed {
    logic [7:0][7:0] src;
    logic            present;
    logic [2:0]      mode;
  } pfc_item_t;

  // load enables for the two arithmetic stages
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } pfc_stage_en_t;

  typedef struct packed {
    logic signed [27:0] r1;
    logic signed [27:0] g1;
    logic signed [27:0] b1;
    logic signed [27:0] r2;
    logic signed [27:0] g2;
    logic signed [27:0] b2;
  } pfc_ycc_sum_t;

  typedef struct packed {
    logic        [15:0] y1;
    logic        [15:0] y2;
    logic signed [17:0] cb;
    logic signed [17:0] cr;
  } pfc_yuv_sum_t;

endpackage

// ===== rtl/core/pfc_ycc_path.sv =====
// YCbCr to RGB arithmetic: registered products, then registered Q16 sums.
// Depends on pfc_pkg.
module pfc_ycc_path
  import pfc_pkg::*;
(
  input  logic          clk,
  input  pfc_stage_en_t en,
  input  pfc_item_t     item,
  output pfc_ycc_sum_t  sums
);

  logic signed [7:0]  cb;
  logic signed [7:0]  cr;
  logic signed [25:0] p_cr_r;
  logic signed [25:0] p_cr_g;
  logic signed [25:0] p_cb_g;
  logic signed [25:0] p_cb_b;
  logic [7:0]         y1;
  logic [7:0]         y2;
  logic signed [27:0] base1;
  logic signed [27:0] base2;

  // x - 128 is x with the top bit flipped
  assign cb = $signed({~item.src[1][7], item.src[1][6:0]});
  assign cr = $signed({~item.src[3][7], item.src[3][6:0]});

  always_ff @(posedge clk) begin
    if (en.en_mul) begin
      p_cr_r <= 26'(cr) * 26'(Q_CR_R);
      p_cr_g <= 26'(cr) * 26'(Q_CR_G);
      p_cb_g <= 26'(cb) * 26'(Q_CB_G);
      p_cb_b <= 26'(cb) * 26'(Q_CB_B);
      y1     <= item.src[0];
      y2     <= item.src[2];
    end
  end

  assign base1 = $signed({4'b0000, y1, 16'h0000});
  assign base2 = $signed({4'b0000, y2, 16'h0000});

  always_ff @(posedge clk) begin
    if (en.en_sum) begin
      sums.r1 <= base1 + 28'(p_cr_r);
      sums.g1 <= base1 - 28'(p_cr_g) - 28'(p_cb_g);
      sums.b1 <= base1 + 28'(p_cb_b);
      sums.r2 <= base2 + 28'(p_cr_r);
      sums.g2 <= base2 - 28'(p_cr_g) - 28'(p_cb_g);
      sums.b2 <= base2 + 28'(p_cb_b);
    end
  end

endmodule

// ===== rtl/core/pfc_yuv_path.sv =====
// RGB to YCbCr arithmetic: registered products, then registered Q8 sums.
// Depends on pfc_pkg.
module pfc_yuv_path
  import pfc_pkg::*;
(
  input  logic          clk,
  input  pfc_stage_en_t en,
  input  pfc_item_t     item,
  output pfc_yuv_sum_t  sums
);

  logic [15:0] p_y_r1, p_y_g1, p_y_b1;
  logic [15:0] p_y_r2, p_y_g2, p_y_b2;
  logic [15:0] p_cb_r, p_cb_g, p_cb_b;
  logic [15:0] p_cr_r, p_cr_g, p_cr_b;

  always_ff @(posedge clk) begin
    if (en.en_mul) begin
      p_y_r1 <= {8'd0, item.src[2]} * {8'd0, C_Y_R};
      p_y_g1 <= {8'd0, item.src[1]} * {8'd0, C_Y_G};
      p_y_b1 <= {8'd0, item.src[0]} * {8'd0, C_Y_B};
      p_y_r2 <= {8'd0, item.src[5]} * {8'd0, C_Y_R};
      p_y_g2 <= {8'd0, item.src[4]} * {8'd0, C_Y_G};
      p_y_b2 <= {8'd0, item.src[3]} * {8'd0, C_Y_B};
      // chroma from the first pixel only
      p_cb_r <= {8'd0, item.src[2]} * {8'd0, C_CB_R};
      p_cb_g <= {8'd0, item.src[1]} * {8'd0, C_CB_G};
      p_cb_b <= {8'd0, item.src[0]} * {8'd0, C_CB_B};
      p_cr_r <= {8'd0, item.src[2]} * {8'd0, C_CR_R};
      p_cr_g <= {8'd0, item.src[1]} * {8'd0, C_CR_G};
      p_cr_b <= {8'd0, item.src[0]} * {8'd0, C_CR_B};
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_sum) begin
      sums.y1 <= p_y_r1 + p_y_g1 + p_y_b1;
      sums.y2 <= p_y_r2 + p_y_g2 + p_y_b2;
      sums.cb <= $signed({2'b00, p_cb_b}) - $signed({2'b00, p_cb_r})
                 - $signed({2'b00, p_cb_g});
      sums.cr <= $signed({2'b00, p_cr_r}) - $signed({2'b00, p_cr_g})
                 - $signed({2'b00, p_cr_b});
    end
  end

endmodule

// ===== rtl/core/pfc_pack.sv =====
// Final stage logic: saturation, mode select and word packing.
// Depends on pfc_pkg; feeds the output register in the top level.
module pfc_pack
  import pfc_pkg::*;
(
  input  pfc_item_t    item,
  input  pfc_ycc_sum_t ycc,
  input  pfc_yuv_sum_t yuv,
  output logic [31:0]  word0,
  output logic [31:0]  word1,
  output logic [1:0]   count
);

  function automatic logic [7:0] sat_q16(input logic signed [27:0] acc);
    logic [7:0] res;
    if (acc[27]) begin
      res = 8'd0;
    end else if (|acc[26:24]) begin
      res = 8'hff;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  // 128 + s/256 with truncation toward zero, clamped to a byte
  function automatic logic [7:0] sat_chroma(input logic signed [17:0] s);
    logic signed [17:0] q;
    logic signed [17:0] v;
    logic [7:0]         res;
    q = (s + (s[17] ? 18'sd255 : 18'sd0)) >>> 8;
    v = q + 18'sd128;
    if (v[17]) begin
      res = 8'd0;
    end else if (|v[16:8]) begin
      res = 8'hff;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  always_comb begin
    word0 = 32'd0;
    word1 = 32'd0;
    count = 2'd0;
    case (item.mode)
      MODE_COPY: begin
        word0 = {item.src[3], item.src[2], item.src[1], item.src[0]};
        count = 2'd1;
        if (item.present) begin
          word1 = {item.src[7], item.src[6], item.src[5], item.src[4]};
          count = 2'd2;
        end
      end
      MODE_RGB24: begin
        word0 = {ALPHA_OPAQUE, item.src[2], item.src[1], item.src[0]};
        count = 2'd1;
        if (item.present) begin
          word1 = {ALPHA_OPAQUE, item.src[5], item.src[4], item.src[3]};
          count = 2'd2;
        end
      end
      MODE_YCC: begin
        word0 = {ALPHA_OPAQUE, sat_q16(ycc.r1), sat_q16(ycc.g1), sat_q16(ycc.b1)};
        word1 = {ALPHA_OPAQUE, sat_q16(ycc.r2), sat_q16(ycc.g2), sat_q16(ycc.b2)};
        count = 2'd2;
      end
      MODE_YUYV: begin
        // luma sums never exceed 255*256, so the high byte is the quotient
        word0 = {sat_chroma(yuv.cr), yuv.y2[15:8], sat_chroma(yuv.cb), yuv.y1[15:8]};
        count = 2'd1;
      end
      default: begin
        word0 = 32'd0;
        word1 = 32'd0;
        count = 2'd0;
      end
    endcase
  end

endmodule

// ===== rtl/core/pixel_format_converter_core.sv =====
// Pixel format converter: one pixel pair per transaction, one result each.
// The block takes a new item every clock cycle while the result side keeps
// up. An item runs through four register stages (input register, products,
// sums, output register). A stall on the result side backs up one stage at a
// time, so bubbles are squeezed out before src_stall rises. conversion_mode
// is sampled when an item is accepted; cfg_ready is always high.
module pixel_format_converter_core
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  src_byte0,
  input  logic [7:0]  src_byte1,
  input  logic [7:0]  src_byte2,
  input  logic [7:0]  src_byte3,
  input  logic [7:0]  src_byte4,
  input  logic [7:0]  src_byte5,
  input  logic [7:0]  src_byte6,
  input  logic [7:0]  src_byte7,
  input  logic        second_pixel_present,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [1:0]  words_valid
);

  logic [2:0]    conversion_mode;
  logic          v1, v2, v3;
  pfc_item_t     item1, item2, item3;
  pfc_stage_en_t en;
  logic          en_out;
  logic          en_in;
  pfc_ycc_sum_t  ycc_sums;
  pfc_yuv_sum_t  yuv_sums;
  logic [31:0]   word0_next;
  logic [31:0]   word1_next;
  logic [1:0]    count_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= MODE_COPY;
    end else if (cfg_valid && cfg_ready) begin
      conversion_mode <= cfg_data;
    end
  end

  // each stage loads when empty or when the next one moves
  assign en_out    = !dst_valid || !dst_stall;
  assign en.en_sum = !v3 || en_out;
  assign en.en_mul = !v2 || en.en_sum;
  assign en_in     = !v1 || en.en_mul;
  assign src_stall = !en_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (en_in)     v1        <= src_valid;
      if (en.en_mul) v2        <= v1;
      if (en.en_sum) v3        <= v2;
      if (en_out)    dst_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) begin
      item1.src     <= {src_byte7, src_byte6, src_byte5, src_byte4,
                        src_byte3, src_byte2, src_byte1, src_byte0};
      item1.present <= second_pixel_present;
      item1.mode    <= conversion_mode;
    end
    if (en.en_mul) item2 <= item1;
    if (en.en_sum) item3 <= item2;
  end

  pfc_ycc_path u_ycc (
    .clk  (clk),
    .en   (en),
    .item (item1),
    .sums (ycc_sums)
  );

  pfc_yuv_path u_yuv (
    .clk  (clk),
    .en   (en),
    .item (item1),
    .sums (yuv_sums)
  );

  pfc_pack u_pack (
    .item  (item3),
    .ycc   (ycc_sums),
    .yuv   (yuv_sums),
    .word0 (word0_next),
    .word1 (word1_next),
    .count (count_next)
  );

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_word0   <= word0_next;
      out_word1   <= word1_next;
      words_valid <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (v1 && v2 && v3 && dst_valid && dst_stall))
    else $error("input stalled while the pipe has room");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en_out) |=> v3)
    else $error("sum stage item dropped under stall");

  a_mul_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en.en_sum) |=> (v2 && $stable(item2)))
    else $error("product stage item changed under stall");
`endif

endmodule
